// File: design/bwf_pkg.sv
// bwf_pkg: widths, register codes, polynomial tables and pipeline depths
// for the barrier form factor block. No dependencies.
package bwf_pkg;

  localparam int MOM_W      = 19;
  localparam int RAD_W      = 15;
  localparam int ORD_W      = 3;
  localparam int CFG_DATA_W = 19;
  localparam int FAC_W      = 32;
  localparam int ACC_W      = 64;
  localparam int PROD_W     = MOM_W + RAD_W;
  localparam int ZQ_W       = PROD_W - 4;
  localparam int X48_W      = 2 * ZQ_W;
  localparam int FB_W       = 6;
  localparam int COEF_W     = 20;
  localparam int NSTEP      = 4;
  localparam int POLY_LAT   = 3 + 2 * NSTEP;
  localparam int NUM_W      = ACC_W + 32;
  localparam int DIV_BITS   = NUM_W;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int PIPE_LAT   = POLY_LAT + DIV_BITS + SQRT_STEPS;

  localparam logic [FAC_W-1:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [FAC_W-1:0] FACTOR_MAX = 32'hFFFF_FFFF;
  localparam logic [RAD_W-1:0] RADIUS_RST = 15'd6144;

  typedef enum logic [1:0] {
    CFG_ORDER   = 2'd0,
    CFG_RADIUS  = 2'd1,
    CFG_NOMINAL = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic [RAD_W-1:0] radius;
  } poly_cfg_t;

  // fraction bits of the polynomial accumulator for each order
  function automatic logic [FB_W-1:0] frac_bits(input logic [ORD_W-1:0] order);
    logic [FB_W-1:0] f;
    case (order)
      3'd1:    f = 6'd50;
      3'd2:    f = 6'd38;
      3'd3:    f = 6'd26;
      3'd4:    f = 6'd14;
      3'd5:    f = 6'd2;
      default: f = 6'd50;
    endcase
    return f;
  endfunction

  // Horner coefficients, highest power first after the leading x
  function automatic logic [COEF_W-1:0] coef(input logic [ORD_W-1:0] order,
                                             input logic [2:0] idx);
    logic [COEF_W-1:0] c;
    c = '0;
    case (order)
      3'd1: c = (idx == 3'd0) ? 20'd1 : 20'd0;
      3'd2: begin
        case (idx)
          3'd0:    c = 20'd3;
          3'd1:    c = 20'd9;
          default: c = 20'd0;
        endcase
      end
      3'd3: begin
        case (idx)
          3'd0:    c = 20'd6;
          3'd1:    c = 20'd45;
          3'd2:    c = 20'd225;
          default: c = 20'd0;
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0:    c = 20'd10;
          3'd1:    c = 20'd135;
          3'd2:    c = 20'd1575;
          3'd3:    c = 20'd11025;
          default: c = 20'd0;
        endcase
      end
      3'd5: begin
        case (idx)
          3'd0:    c = 20'd15;
          3'd1:    c = 20'd315;
          3'd2:    c = 20'd6300;
          3'd3:    c = 20'd99225;
          3'd4:    c = 20'd893025;
          default: c = 20'd0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic order_active(input logic [ORD_W-1:0] order);
    return (order >= 3'd1) && (order <= 3'd5);
  endfunction

endpackage

// File: design/barrier_form_factor_top.sv
// barrier_form_factor_top: normalised barrier factor sqrt(D(z0)/D(z)).
// Depends on bwf_pkg, bwf_poly, bwf_div, bwf_sqrt.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------
//   input    | in_valid / in_stall     | momentum (Q3.16)
//   output   | out_valid / out_stall   | factor (Q16.16), saturated
//   config   | cfg_write (no wait)     | cfg_index, cfg_data
//
// One item per cycle unless the skid register is full. It has 11 stages
// of polynomial (zq, square, Horner with split 64x64 products), 96 divider
// stages of one quotient bit each, 32 square-root stages, one output stage.
// Synchronous reset clears config to defaults and empties the pipeline.
// A stalled result parks in a skid register; the pipe freezes only once
// that register is full, so in_stall is that register or rst and never a
// path from out_stall.
module barrier_form_factor_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bwf_pkg::MOM_W-1:0]       momentum,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bwf_pkg::FAC_W-1:0]       factor,
  output logic                            saturated,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [bwf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bwf_pkg::*;

  logic [ORD_W-1:0]    orbital_order;
  logic [RAD_W-1:0]    radius;
  logic [MOM_W-1:0]    nominal_momentum;
  poly_cfg_t           pcfg;
  logic                en;
  logic                skid_v;
  logic [PIPE_LAT-1:0] vld;
  logic                fin_v;
  logic [ACC_W-1:0]    d, d0;
  logic [NUM_W-1:0]    quo;
  logic [ROOT_W-1:0]   root;
  logic                over;
  logic [FAC_W-1:0]    res_fac, skid_fac;
  logic                res_sat, skid_sat;

  // config registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      orbital_order    <= '0;
      radius           <= RADIUS_RST;
      nominal_momentum <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORDER:   orbital_order    <= cfg_data[ORD_W-1:0];
        CFG_RADIUS:  radius           <= cfg_data[RAD_W-1:0];
        CFG_NOMINAL: nominal_momentum <= cfg_data[MOM_W-1:0];
        default:     ;
      endcase
    end
  end

  assign pcfg     = '{order: orbital_order, radius: radius};
  assign en       = !skid_v;
  assign in_stall = skid_v || rst;

  // valid bits travel alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // D(z) for the item and D(z0) for the nominal momentum, side by side
  bwf_poly u_poly (
    .clk (clk),
    .en  (en),
    .cfg (pcfg),
    .mom (momentum),
    .d   (d)
  );

  bwf_poly u_poly_nom (
    .clk (clk),
    .en  (en),
    .cfg (pcfg),
    .mom (nominal_momentum),
    .d   (d0)
  );

  bwf_div u_div (
    .clk (clk),
    .en  (en),
    .d0  (d0),
    .d   (d),
    .quo (quo)
  );

  // any quotient bit above 2^63 means the ratio does not fit Q32.32
  bwf_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .val      (quo[ACC_W-1:0]),
    .over_in  (|quo[NUM_W-1:ACC_W]),
    .root     (root),
    .over_out (over)
  );

  always_comb begin
    if (!order_active(orbital_order)) begin
      res_fac = ONE_Q16;
      res_sat = 1'b0;
    end else if (over) begin
      res_fac = FACTOR_MAX;
      res_sat = 1'b1;
    end else begin
      res_fac = root;
      res_sat = 1'b0;
    end
  end

  assign fin_v = vld[PIPE_LAT-1] && en;

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= skid_v || fin_v;
      skid_v    <= 1'b0;
    end else if (fin_v) begin
      skid_v    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      factor    <= skid_v ? skid_fac : res_fac;
      saturated <= skid_v ? skid_sat : res_sat;
    end else if (fin_v) begin
      skid_fac  <= res_fac;
      skid_sat  <= res_sat;
    end
  end

endmodule

// File: design/bwf_poly.sv
// bwf_poly: pipelined barrier polynomial D(z) for one momentum.
// Depends on bwf_pkg. One item per cycle while en is high.
module bwf_poly (
  input  logic                        clk,
  input  logic                        en,
  input  bwf_pkg::poly_cfg_t          cfg,
  input  logic [bwf_pkg::MOM_W-1:0]   mom,
  output logic [bwf_pkg::ACC_W-1:0]   d
);
  import bwf_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [X48_W-1:0]  x48;
  logic [FB_W-1:0]   f;
  logic [ACC_W-1:0]  xw, xs, acc0;
  logic [ACC_W-1:0]  acc_st [NSTEP+1];
  logic [ACC_W-1:0]  x_st   [NSTEP+1];
  logic [ACC_W-1:0]  pa_acc [1:NSTEP];
  logic [ACC_W-1:0]  pa_x   [1:NSTEP];
  logic [63:0]       pp_ll  [1:NSTEP];
  logic [63:0]       pp_lh  [1:NSTEP];
  logic [63:0]       pp_hl  [1:NSTEP];
  logic [63:0]       pp_hh  [1:NSTEP];

  assign f = frac_bits(cfg.order);

  // z = p * r in Q6.24, then its square
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(mom) * PROD_W'(cfg.radius);
      x48  <= X48_W'(prod[PROD_W-1:4]) * X48_W'(prod[PROD_W-1:4]);
    end
  end

  always_comb begin
    xw   = ACC_W'(x48);
    xs   = (f >= 6'd48) ? (xw << (f - 6'd48)) : (xw >> (6'd48 - f));
    acc0 = xs + (ACC_W'(coef(cfg.order, 3'd0)) << f);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_st[0] <= acc0;
      x_st[0]   <= xs;
    end
  end

  for (genvar s = 1; s <= NSTEP; s++) begin : g_step
    logic [127:0]     p;
    logic [127:0]     sh;
    logic [ACC_W-1:0] nacc;

    // partial products of acc * x
    always_ff @(posedge clk) begin
      if (en) begin
        pp_ll[s]  <= 64'(acc_st[s-1][31:0])  * 64'(x_st[s-1][31:0]);
        pp_lh[s]  <= 64'(acc_st[s-1][31:0])  * 64'(x_st[s-1][63:32]);
        pp_hl[s]  <= 64'(acc_st[s-1][63:32]) * 64'(x_st[s-1][31:0]);
        pp_hh[s]  <= 64'(acc_st[s-1][63:32]) * 64'(x_st[s-1][63:32]);
        pa_acc[s] <= acc_st[s-1];
        pa_x[s]   <= x_st[s-1];
      end
    end

    always_comb begin
      p    = {pp_hh[s], 64'b0} + {32'b0, pp_lh[s], 32'b0}
           + {32'b0, pp_hl[s], 32'b0} + {64'b0, pp_ll[s]};
      sh   = p >> f;
      nacc = sh[ACC_W-1:0] + (ACC_W'(coef(cfg.order, 3'(s))) << f);
    end

    // steps beyond the order pass the accumulator through
    always_ff @(posedge clk) begin
      if (en) begin
        acc_st[s] <= (3'(s) < cfg.order) ? nacc : pa_acc[s];
        x_st[s]   <= pa_x[s];
      end
    end
  end

  assign d = acc_st[NSTEP];

endmodule

// File: design/bwf_div.sv
// bwf_div: restoring divider of (d0 * 2^32) by d, one quotient bit per stage.
// Depends on bwf_pkg.
module bwf_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bwf_pkg::ACC_W-1:0]   d0,
  input  logic [bwf_pkg::ACC_W-1:0]   d,
  output logic [bwf_pkg::NUM_W-1:0]   quo
);
  import bwf_pkg::*;

  logic [ACC_W-1:0] rem [DIV_BITS+1];
  logic [NUM_W-1:0] num [DIV_BITS+1];
  logic [ACC_W-1:0] dv  [DIV_BITS+1];

  assign rem[0] = '0;
  assign num[0] = {d0, 32'b0};
  assign dv[0]  = d;

  // dividend bits shift out of the top, quotient bits in at the bottom
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
    logic [ACC_W:0] r2;
    logic           ge;
    logic [ACC_W:0] diff;

    always_comb begin
      r2   = {rem[k], num[k][NUM_W-1]};
      ge   = r2 >= {1'b0, dv[k]};
      diff = r2 - {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[ACC_W-1:0] : r2[ACC_W-1:0];
        num[k+1] <= {num[k][NUM_W-2:0], ge};
        dv[k+1]  <= dv[k];
      end
    end
  end

  assign quo = num[DIV_BITS];

endmodule

// File: design/bwf_sqrt.sv
// bwf_sqrt: pipelined integer square root of a 64-bit value, one result bit
// per stage. Depends on bwf_pkg.
module bwf_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bwf_pkg::ACC_W-1:0]    val,
  input  logic                         over_in,
  output logic [bwf_pkg::ROOT_W-1:0]   root,
  output logic                         over_out
);
  import bwf_pkg::*;

  logic [ACC_W-1:0] v   [SQRT_STEPS+1];
  logic [ACC_W-1:0] res [SQRT_STEPS+1];
  logic             ov  [SQRT_STEPS+1];

  assign v[0]   = val;
  assign res[0] = '0;
  assign ov[0]  = over_in;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (62 - 2 * k);
    logic [ACC_W-1:0] t;
    logic             ge;

    always_comb begin
      t  = res[k] + BIT;
      ge = v[k] >= t;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v[k+1]   <= ge ? (v[k] - t) : v[k];
        res[k+1] <= ge ? ((res[k] >> 1) + BIT) : (res[k] >> 1);
        ov[k+1]  <= ov[k];
      end
    end
  end

  assign root     = res[SQRT_STEPS][ROOT_W-1:0];
  assign over_out = ov[SQRT_STEPS];

endmodule

// File: design/bwf_checker.sv
// bwf_checker: port-level assertions for barrier_form_factor_top, bound in.
// Depends on bwf_pkg.
module bwf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bwf_pkg::FAC_W-1:0]       factor,
  input logic                            saturated
);
  import bwf_pkg::*;

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // saturation always comes with the clamped value
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> factor == FACTOR_MAX)
    else $error("saturated flag without clamped factor");

  // skid drains as soon as the output is taken
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !in_stall)
    else $error("input still stalled after output taken");

  // no backpressure while nothing waits at the output
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(factor) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind barrier_form_factor_top bwf_checker u_bwf_checker (.*);

// File: test/tb_barrier_form_factor_top.sv
// tb_barrier_form_factor_top: self-checking bench for the barrier form factor block.
// Drives momenta through a directed table then random items, predicts each factor
// with an exact local model. Depends on bwf_pkg and barrier_form_factor_top.
`timescale 1ns / 1ps

module tb_barrier_form_factor_top;
  import bwf_pkg::*;

  localparam int LAT = PIPE_LAT + 1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [MOM_W-1:0] momentum = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [FAC_W-1:0] factor;
  logic             saturated;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = CFG_ORDER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  barrier_form_factor_top DUT (.*);

  always #4 clk = ~clk;

  // expected result of one item
  typedef struct packed {
    logic [FAC_W-1:0] fac;
    logic             sat;
  } factor_exp_t;

  factor_exp_t factor_q[$];
  int          n_err = 0;

  // local copy of the registers
  logic [ORD_W-1:0]  cur_order = '0;
  logic [RAD_W-1:0]  cur_radius = RADIUS_RST;
  logic [MOM_W-1:0]  cur_nominal = '0;

  // idling controls: chance in a hundred
  int send_idle = 18;
  int recv_idle = 81;
  bit hold_off  = 1'b0;

  // polynomial D(z) at the given order, F fraction bits
  function automatic logic [63:0] horner_d(logic [MOM_W-1:0] p, int ord);
    int          fb;
    logic [63:0] zq, x48, x, acc;
    logic [127:0] prod;
    int          c[6][5];
    c = '{'{0,0,0,0,0}, '{1,0,0,0,0}, '{3,9,0,0,0}, '{6,45,225,0,0},
          '{10,135,1575,11025,0}, '{15,315,6300,99225,893025}};
    fb  = 62 - 12 * ord;
    zq  = (64'(p) * 64'(cur_radius)) >> 4;
    x48 = zq * zq;
    x   = (fb >= 48) ? (x48 << (fb - 48)) : (x48 >> (48 - fb));
    acc = x + (64'(c[ord][0]) << fb);
    for (int i = 1; i < ord; i++) begin
      prod = 128'(acc) * 128'(x);
      acc  = 64'(prod >> fb) + (64'(c[ord][i]) << fb);
    end
    return acc;
  endfunction

  function automatic factor_exp_t barrier_factor(logic [MOM_W-1:0] p);
    factor_exp_t r;
    logic [63:0]  d, d0;
    logic [127:0] q;
    logic [63:0]  v, res, bt;
    if (cur_order == 0 || cur_order > 5) begin
      r.fac = ONE_Q16;
      r.sat = 1'b0;
      return r;
    end
    d  = horner_d(p, int'(cur_order));
    d0 = horner_d(cur_nominal, int'(cur_order));
    q  = (128'(d0) << 32) / 128'(d);
    if (q[127:64] != 0) begin
      r.fac = FACTOR_MAX;
      r.sat = 1'b1;
      return r;
    end
    // bitwise integer square root
    v = q[63:0];
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    r.fac = res[31:0];
    r.sat = 1'b0;
    return r;
  endfunction

  // register write while the block is idle
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_ORDER:   cur_order   = val[ORD_W-1:0];
      CFG_RADIUS:  cur_radius  = val[RAD_W-1:0];
      CFG_NOMINAL: cur_nominal = val[MOM_W-1:0];
      default: ;
    endcase
  endtask

  // offer one momentum and hold it until taken; optional typed-in result
  task automatic send_item(logic [MOM_W-1:0] p, bit fixed, factor_exp_t fx);
    // idle cycles drop valid so the previous item is not offered again
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    momentum <= p;
    do @(posedge clk); while (in_stall);
    factor_q.push_back(fixed ? fx : barrier_factor(p));
    if (fixed && fx != barrier_factor(p))
      $display("%0t note: table row disagrees with predictor for %h", $time, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (factor_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // receiver: random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  // checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    factor_exp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (factor_q.size() == 0) begin
        $display("%0t unexpected result factor=%h sat=%b", $time, factor, saturated);
        n_err++;
      end else begin
        e = factor_q.pop_front();
        if (factor !== e.fac) begin
          $display("%0t factor mismatch: expected %h actual %h", $time, e.fac, factor);
          n_err++;
        end
        if (saturated !== e.sat) begin
          $display("%0t saturated mismatch: expected %b actual %b", $time, e.sat,
                   saturated);
          n_err++;
        end
      end
    end
  end

  // directed table: momentum, whether the result is typed in, that result
  typedef struct {
    logic [MOM_W-1:0] mom;
    bit               fixed;
    logic [FAC_W-1:0] fac;
    logic             sat;
  } dir_row_t;

  initial begin
    dir_row_t    rows[$];
    factor_exp_t fx;
    logic [MOM_W-1:0] p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // after reset: order zero gives one for any momentum
    rows = '{'{19'd0, 1, ONE_Q16, 0}, '{19'h7FFFF, 1, ONE_Q16, 0},
             '{19'h10000, 1, ONE_Q16, 0}};
    foreach (rows[i]) begin
      fx.fac = rows[i].fac;
      fx.sat = rows[i].sat;
      send_item(rows[i].mom, rows[i].fixed, fx);
    end
    drain();

    // each order with zero nominal: zero momentum gives exactly one
    for (int o = 1; o <= 7; o++) begin
      write_reg(CFG_ORDER, CFG_DATA_W'(o));
      fx.fac = ONE_Q16;
      fx.sat = 1'b0;
      send_item(19'd0, 1, fx);
      send_item(19'h7FFFF, 0, fx);
      send_item(19'h08000, 0, fx);
      drain();
    end

    // overflow: large nominal, small momentum, order 5, largest radius
    write_reg(CFG_ORDER, CFG_DATA_W'(5));
    write_reg(CFG_RADIUS, 19'h7FFF);
    write_reg(CFG_NOMINAL, 19'h7FFFF);
    fx.fac = FACTOR_MAX;
    fx.sat = 1'b1;
    send_item(19'd0, 1, fx);
    send_item(19'h7FFFF, 0, fx);
    drain();
    // zero radius: z is zero on both sides, result one
    write_reg(CFG_RADIUS, CFG_DATA_W'(0));
    fx.fac = ONE_Q16;
    fx.sat = 1'b0;
    send_item(19'h7FFFF, 1, fx);
    send_item(19'h00001, 1, fx);
    drain();

    // random phases: idling pattern, registers changed between phases
    for (int ph = 0; ph < 12; ph++) begin
      send_idle = (ph < 4) ? 18 : (ph < 8) ? 81 : 0;
      recv_idle = (ph < 4) ? 81 : (ph < 8) ? 18 : 0;
      write_reg(CFG_ORDER, CFG_DATA_W'((ph < 10) ? ph % 6 : 6 + ph % 2));
      case (ph % 4)
        0: write_reg(CFG_RADIUS, 19'h7FFF);
        1: write_reg(CFG_RADIUS, CFG_DATA_W'(0));
        default: write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(32767)));
      endcase
      case (ph % 3)
        0: write_reg(CFG_NOMINAL, CFG_DATA_W'(0));
        1: write_reg(CFG_NOMINAL, 19'h7FFFF);
        default: write_reg(CFG_NOMINAL, CFG_DATA_W'($urandom_range(524287)));
      endcase
      // long hold-off once, while the sender keeps offering
      if (ph == 9) fork
        begin
          hold_off = 1'b1;
          repeat (400) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      // the hold-off phase offers more items than the pipe holds
      for (int k = 0; k < ((ph == 9) ? 200 : 58); k++) begin
        case ($urandom_range(3))
          0: p = MOM_W'($urandom_range(524287));
          1: p = MOM_W'($urandom_range(4095));
          2: p = {MOM_W{1'b1}} ^ MOM_W'($urandom_range(255));
          default: p = MOM_W'($urandom_range(131071));
        endcase
        send_item(p, 0, fx);
      end
      drain();
    end

    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
